/* src/pgc_pkg.sv */
// Package for the pixel gamma converter.
// Holds operation codes, curve selection codes and the configuration struct.
// No dependencies.
package pgc_pkg;

  // Fixed channel width of one color component.
  localparam int ChannelBits = 8;
  localparam logic [ChannelBits-1:0] MaxCode = 8'd255;

  // Configuration register indexes.
  localparam logic [1:0] REG_CURVE_MODE     = 2'd0;
  localparam logic [1:0] REG_POWER_EXPONENT = 2'd1;
  localparam logic [1:0] REG_SINGLE_CHANNEL = 2'd2;

  // Operation codes carried by an input word.
  localparam logic [1:0] OP_DECODE = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_PASS   = 2'd2;

  // Which comparison the search stages apply.
  typedef enum logic [1:0] {
    K_SRGB_DEC = 2'd0,
    K_SRGB_ENC = 2'd1,
    K_POW_DEC  = 2'd2,
    K_POW_ENC  = 2'd3
  } kind_t;

  // Curve configuration seen by every lane.
  typedef struct packed {
    logic        curve_mode;
    logic [15:0] power_exponent;
  } cfg_t;

endpackage

/* src/pgc_lane.sv */
// One channel lane: threshold stage followed by an eight-stage binary search
// for the largest output code whose log value clears the threshold.
// Depends on pgc_pkg.
module pgc_lane #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                              clk,
  input  logic [pgc_pkg::ChannelBits-1:0]   in_code,
  input  logic [1:0]                        in_op,
  input  pgc_pkg::cfg_t                     cfg,
  output logic [pgc_pkg::ChannelBits-1:0]   out_code
);

  localparam int CB = pgc_pkg::ChannelBits;
  localparam int LW = FRACTION_BITS + 5;   // log2 of values below 2^16
  localparam int NW = FRACTION_BITS + 4;   // negated log differences
  localparam int FW = FRACTION_BITS + 21;  // weighted compare values
  localparam int DEPTH = 1 << CB;

  typedef logic [NW-1:0] tab_t [DEPTH];

  // Log2 with FRACTION_BITS fraction bits by repeated squaring (elaboration only).
  function automatic logic [LW-1:0] lg_f(input int unsigned n);
    int unsigned     nn;
    int unsigned     p;
    longint unsigned m;
    longint unsigned frac;
    nn = (n == 0) ? 1 : n;
    p = 0;
    frac = 0;
    while ((nn >> p) > 1) p++;
    m = (longint'(nn) << FRACTION_BITS) >> p;
    for (int i = 0; i < FRACTION_BITS; i++) begin
      m = (m * m) >> FRACTION_BITS;
      frac = frac << 1;
      if (m >= (longint'(2) << FRACTION_BITS)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return LW'((longint'(p) << FRACTION_BITS) | frac);
  endfunction

  function automatic tab_t build_nl();
    tab_t t;
    for (int k = 0; k < DEPTH; k++) begin
      t[k] = NW'(lg_f(DEPTH - 1) - lg_f(k));
    end
    return t;
  endfunction

  function automatic tab_t build_nlb();
    tab_t t;
    for (int k = 0; k < DEPTH; k++) begin
      t[k] = NW'(lg_f(211 * (DEPTH - 1)) - lg_f(200 * k + 11 * (DEPTH - 1)));
    end
    return t;
  endfunction

  localparam tab_t NL_TAB  = build_nl();
  localparam tab_t NLB_TAB = build_nlb();

  // Pipeline registers, index 0 is the threshold stage.
  pgc_pkg::kind_t  kind_r [CB+1];
  logic            fix_r  [CB+1];
  logic [CB-1:0]   fixv_r [CB+1];
  logic [15:0]     exp_r  [CB+1];
  logic [FW-1:0]   t_r    [CB+1];
  logic [CB-1:0]   acc_r  [CB+1];

  pgc_pkg::kind_t  kind_nxt;
  logic            fix_nxt;
  logic [CB-1:0]   fixv_nxt;
  logic [FW-1:0]   t_nxt;
  logic [NW-1:0]   nlc;
  logic [NW-1:0]   nlbc;
  logic            is_dec;
  logic            is_enc;

  // Threshold, curve kind and the cases that need no search.
  always_comb begin
    is_dec = (in_op == pgc_pkg::OP_DECODE);
    is_enc = (in_op == pgc_pkg::OP_ENCODE);
    nlc  = NL_TAB[in_code];
    nlbc = NLB_TAB[in_code];
    if (cfg.curve_mode) begin
      kind_nxt = is_enc ? pgc_pkg::K_POW_ENC : pgc_pkg::K_POW_DEC;
    end else begin
      kind_nxt = is_enc ? pgc_pkg::K_SRGB_ENC : pgc_pkg::K_SRGB_DEC;
    end
    case (kind_nxt)
      pgc_pkg::K_SRGB_DEC: t_nxt = FW'(nlbc) * FW'(12);
      pgc_pkg::K_SRGB_ENC: t_nxt = FW'(nlc) * FW'(5);
      pgc_pkg::K_POW_DEC:  t_nxt = FW'(cfg.power_exponent) * FW'(nlc);
      pgc_pkg::K_POW_ENC:  t_nxt = FW'(nlc) << 12;
      default:             t_nxt = '0;
    endcase
    fix_nxt  = 1'b0;
    fixv_nxt = '0;
    if (!is_dec && !is_enc) begin
      fix_nxt  = 1'b1;
      fixv_nxt = in_code;
    end else if (!cfg.curve_mode) begin
      // Linear segment near black always rounds down to zero.
      if (is_dec && in_code <= CB'(10)) fix_nxt = 1'b1;
      if (is_enc && in_code == '0) fix_nxt = 1'b1;
    end else if (in_code == '0) begin
      fix_nxt  = 1'b1;
      fixv_nxt = (is_dec && cfg.power_exponent == '0) ? pgc_pkg::MaxCode : '0;
    end
  end

  always_ff @(posedge clk) begin
    kind_r[0] <= kind_nxt;
    fix_r[0]  <= fix_nxt;
    fixv_r[0] <= fixv_nxt;
    exp_r[0]  <= cfg.power_exponent;
    t_r[0]    <= t_nxt;
    acc_r[0]  <= '0;
  end

  // One result bit per stage, most significant first.
  for (genvar s = 0; s < CB; s++) begin : g_search
    localparam int B = CB - 1 - s;
    logic [CB-1:0] cand;
    logic [NW-1:0] nlk;
    logic [NW-1:0] nlbk;
    logic [FW-1:0] f_val;
    logic          hit;

    always_comb begin
      cand = acc_r[s] | (CB'(1) << B);
      nlk  = NL_TAB[cand];
      nlbk = NLB_TAB[cand];
      case (kind_r[s])
        pgc_pkg::K_SRGB_DEC: f_val = FW'(nlk) * FW'(5);
        pgc_pkg::K_SRGB_ENC: f_val = FW'(nlbk) * FW'(12);
        pgc_pkg::K_POW_DEC:  f_val = FW'(nlk) << 12;
        pgc_pkg::K_POW_ENC:  f_val = FW'(nlk) * FW'(exp_r[s]);
        default:             f_val = '0;
      endcase
      hit = (f_val >= t_r[s]);
    end

    always_ff @(posedge clk) begin
      kind_r[s+1] <= kind_r[s];
      fix_r[s+1]  <= fix_r[s];
      fixv_r[s+1] <= fixv_r[s];
      exp_r[s+1]  <= exp_r[s];
      t_r[s+1]    <= t_r[s];
      acc_r[s+1]  <= hit ? cand : acc_r[s];
    end
  end

  assign out_code = fix_r[CB] ? fixv_r[CB] : acc_r[CB];

endmodule

/* src/pgc_merge.sv */
// Merge stage: optional gray average of the three lanes and the output register.
// Depends on pgc_pkg.
module pgc_merge (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             single_channel,
  input  logic [pgc_pkg::ChannelBits-1:0]  in_red,
  input  logic [pgc_pkg::ChannelBits-1:0]  in_green,
  input  logic [pgc_pkg::ChannelBits-1:0]  in_blue,
  output logic                             out_valid,
  output logic [pgc_pkg::ChannelBits-1:0]  out_red,
  output logic [pgc_pkg::ChannelBits-1:0]  out_green,
  output logic [pgc_pkg::ChannelBits-1:0]  out_blue
);

  localparam int CB = pgc_pkg::ChannelBits;

  logic          valid_r;
  logic [CB-1:0] red_r;
  logic [CB-1:0] green_r;
  logic [CB-1:0] blue_r;
  logic [CB+1:0] sum;
  logic [2*CB+3:0] prod;
  logic [CB-1:0] avg;

  // Divide by three through a reciprocal multiply, exact for sums up to 765.
  always_comb begin
    sum  = (CB+2)'(in_red) + (CB+2)'(in_green) + (CB+2)'(in_blue);
    prod = (2*CB+4)'(sum) * (2*CB+4)'(683);
    avg  = CB'(prod >> 11);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    red_r   <= single_channel ? avg : in_red;
    green_r <= single_channel ? avg : in_green;
    blue_r  <= single_channel ? avg : in_blue;
  end

  assign out_valid = valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

/* src/pixel_gamma_converter_unit.sv */
// Top level of the pixel gamma converter: three channel lanes and a merge stage.
// Depends on pgc_pkg, pgc_lane and pgc_merge.
//
// A pixel word is taken in every clock cycle (busy is always low) and its
// converted word appears on the out_ ports with out_strobe. A threshold stage
// forms the log threshold, search stages find the output code by binary search,
// one bit each, and the merge stage optionally averages and registers the
// result. The receiver cannot stall, so every strobe must be taken.
// Configuration must be written only while no pixel is in flight (not enforced).
module pixel_gamma_converter_unit #(
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  output logic        out_strobe,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CB = pgc_pkg::ChannelBits;

  logic          curve_mode_r;
  logic [15:0]   power_exponent_r;
  logic          single_channel_r;
  logic [CB:0]   vld_r;
  logic          accept;
  pgc_pkg::cfg_t cfg;
  logic [CB-1:0] red_lane;
  logic [CB-1:0] green_lane;
  logic [CB-1:0] blue_lane;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign cfg.curve_mode     = curve_mode_r;
  assign cfg.power_exponent = power_exponent_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_mode_r     <= 1'b0;
      power_exponent_r <= 16'd9011;
      single_channel_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        pgc_pkg::REG_CURVE_MODE:     curve_mode_r     <= cfg_data[0];
        pgc_pkg::REG_POWER_EXPONENT: power_exponent_r <= cfg_data;
        pgc_pkg::REG_SINGLE_CHANNEL: single_channel_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Valid marks that follow each word through the lane pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[CB-1:0], accept};
    end
  end

  pgc_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_red (
    .clk(clk), .in_code(in_red_in), .in_op(in_operation), .cfg(cfg), .out_code(red_lane)
  );
  pgc_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_green (
    .clk(clk), .in_code(in_green_in), .in_op(in_operation), .cfg(cfg), .out_code(green_lane)
  );
  pgc_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_blue (
    .clk(clk), .in_code(in_blue_in), .in_op(in_operation), .cfg(cfg), .out_code(blue_lane)
  );

  pgc_merge u_merge (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(vld_r[CB]),
    .single_channel(single_channel_r),
    .in_red(red_lane),
    .in_green(green_lane),
    .in_blue(blue_lane),
    .out_valid(out_strobe),
    .out_red(out_red_out),
    .out_green(out_green_out),
    .out_blue(out_blue_out)
  );

endmodule

/* src/pgc_checker.sv */
// Port-level checks for the pixel gamma converter and their bind.
// Depends on pgc_pkg and pixel_gamma_converter_unit.
module pgc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_operation,
  input logic [7:0] in_red_in,
  input logic [7:0] in_green_in,
  input logic [7:0] in_blue_in,
  input logic       out_strobe,
  input logic [7:0] out_red_out,
  input logic [7:0] out_green_out,
  input logic [7:0] out_blue_out
);

  // The block never refuses a word.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // Every accepted word produces a result strobe.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##9 out_strobe)
    else $error("result missing after accepted word");

  // No result without an earlier accepted word.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy && rst_n, 10))
    else $error("result without a word");

  // A gray word passed through stays gray in either output mode.
  a_gray_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation == pgc_pkg::OP_PASS &&
     in_red_in == in_green_in && in_green_in == in_blue_in) |=> ##9
    (out_red_out == out_green_out && out_green_out == out_blue_out))
    else $error("gray pass-through word changed");

endmodule

bind pixel_gamma_converter_unit pgc_checker u_pgc_checker (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .in_operation(in_operation),
  .in_red_in(in_red_in),
  .in_green_in(in_green_in),
  .in_blue_in(in_blue_in),
  .out_strobe(out_strobe),
  .out_red_out(out_red_out),
  .out_green_out(out_green_out),
  .out_blue_out(out_blue_out)
);
